// ===== design/bsr_pkg.sv =====
// shared types and constants for the box support relabel block
package bsr_pkg;

	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 21;
	localparam int WIDTH_BITS = 11;
	localparam int HEIGHT_BITS = 21;
	localparam int SUPPORT_BITS = 6;
	localparam int RATIO_BITS = 7;
	localparam int PIX_BITS = 8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WIDTH = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_SUPPORT = 2'd2,
		CFG_RATIO = 2'd3
	} cfg_idx_t;

	localparam logic [1:0] CODE_NONE = 2'd0;
	localparam logic [1:0] CODE_PARTIAL = 2'd1;
	localparam logic [1:0] CODE_COPIED = 2'd2;

	localparam logic [PIX_BITS-1:0] PIX_FULL = 8'd255;
	localparam logic [PIX_BITS-1:0] PIX_COPIED = 8'd170;
	localparam logic [PIX_BITS-1:0] PIX_PARTIAL = 8'd85;
	localparam logic [PIX_BITS-1:0] PIX_NONE = 8'd0;
	localparam logic [RATIO_BITS-1:0] PERCENT = 7'd100;

	typedef struct packed {
		logic ld_in;
		logic ld_cfg;
		logic decide;
		logic div_go_q;
		logic ld_oxy;
		logic ld_bounds;
		logic ld_base;
		logic ld_addr1;
		logic ld_addr2;
		logic scan_step;
		logic ld_cmp;
		logic ld_res;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic early;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

// ===== design/bsr_ram.sv =====
// generic single write, single read ram with registered read data
module bsr_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/bsr_div.sv =====
// restoring divider, one quotient bit per cycle
module bsr_div #(
	parameter int DW = 33,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder,
	output logic          done
);

	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [VW:0] shift_d;
	logic [VW:0] diff_d;
	logic take_d;

	assign shift_d = {rem_q, quo_q[DW-1]};
	assign diff_d = shift_d - {1'b0, dvs_q};
	assign take_d = shift_d >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNTW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], take_d};
			rem_q <= take_d ? diff_d[VW-1:0] : shift_d[VW-1:0];
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
	assign done = done_q;

endmodule

// ===== design/bsr_dpath.sv =====
// datapath: config registers, label store, divider, window scan and result register
module bsr_dpath #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SUPPORT = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bsr_pkg::cmd_t                        cmd,
	output bsr_pkg::sts_t                        sts,
	input  logic                                 cfg_valid,
	input  logic [bsr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [bsr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 op,
	input  logic [bsr_pkg::PIX_BITS-1:0]         pixel_in,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic [bsr_pkg::PIX_BITS-1:0]         pixel_out,
	output logic                                 frame_last
);
	import bsr_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(MAX_SUPPORT + 1);
	localparam int HW = HEIGHT_BITS;
	localparam int PW = HW + WW + 1;
	localparam int DEPTH = MAX_SUPPORT * MAX_WIDTH + MAX_SUPPORT;
	localparam int AW = $clog2(DEPTH + 1);
	localparam int RAW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_SUPPORT * MAX_SUPPORT + 1);
	localparam int LW = CW + RATIO_BITS;
	localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);

	function automatic logic [1:0] code_of(logic [PIX_BITS-1:0] p);
		logic [1:0] c;
		if (p == PIX_FULL) begin
			c = CODE_COPIED;
		end else if (p != PIX_NONE) begin
			c = CODE_PARTIAL;
		end else begin
			c = CODE_NONE;
		end
		return c;
	endfunction

	// config registers
	logic [WIDTH_BITS-1:0] width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [SUPPORT_BITS-1:0] support_q;
	logic [RATIO_BITS-1:0] ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1024;
			height_q <= 21'd1024;
			support_q <= 6'd8;
			ratio_q <= 7'd50;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH: width_q <= cfg_data[WIDTH_BITS-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HEIGHT_BITS-1:0];
				CFG_SUPPORT: support_q <= cfg_data[SUPPORT_BITS-1:0];
				CFG_RATIO: ratio_q <= cfg_data[RATIO_BITS-1:0];
			endcase
		end
	end

	// clamped frame geometry
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [SW-1:0] s_eff;
	logic [SW-1:0] lo;
	logic [SW-1:0] hi;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff = (height_q == '0) ? HW'(1) : height_q;
		if (support_q == '0) begin
			s_eff = SW'(1);
		end else if (int'(support_q) > MAX_SUPPORT) begin
			s_eff = SW'(MAX_SUPPORT);
		end else begin
			s_eff = SW'(support_q);
		end
		lo = s_eff >> 1;
		hi = s_eff - lo - SW'(1);
	end

	logic [HW+WW-1:0] hw_prod;
	logic [SW+WW:0] d_full;
	assign hw_prod = h_eff * w_eff;
	assign d_full = hi * w_eff + hi;

	// input beat and position state
	logic op_q;
	logic [PIX_BITS-1:0] pix_q;
	logic [PW-1:0] n_q;
	logic [PW-1:0] d_q;
	logic [AW-1:0] dmod_q;
	logic [PW-1:0] pos_q;
	logic [AW-1:0] pos_mod_q;
	logic [PW-1:0] q_q;
	logic [AW-1:0] qmod_q;

	logic below_n;
	logic below_d;
	logic past_n;
	logic [PW-1:0] q_now;
	logic [AW:0] qm_diff;
	logic [AW-1:0] qmod_next;
	logic [AW-1:0] pos_mod_inc;

	assign below_n = pos_q < n_q;
	assign below_d = pos_q < d_q;
	assign q_now = pos_q - d_q;
	assign past_n = q_now >= n_q;
	assign qm_diff = {1'b0, pos_mod_q} - {1'b0, dmod_q};
	assign qmod_next = (pos_mod_q >= dmod_q) ? AW'(qm_diff) : AW'(qm_diff + DEPTH_X);
	assign pos_mod_inc = (pos_mod_q == AW'(DEPTH - 1)) ? '0 : pos_mod_q + AW'(1);

	logic last_d;
	assign last_d = q_q == (n_q - PW'(1));

	// position and its store address move together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pos_mod_q <= '0;
		end else if (cmd.decide) begin
			if (!(below_n && op_q)) begin
				if (below_d) begin
					pos_q <= pos_q + PW'(1);
					pos_mod_q <= pos_mod_inc;
				end else if (past_n) begin
					pos_q <= '0;
					pos_mod_q <= '0;
				end
			end
		end else if (cmd.ld_res) begin
			if (last_d) begin
				pos_q <= '0;
				pos_mod_q <= '0;
			end else begin
				pos_q <= pos_q + PW'(1);
				pos_mod_q <= pos_mod_inc;
			end
		end
	end

	// divider for the row/column split
	logic [PW-1:0] div_quo;
	logic [WW-1:0] div_rem;
	logic div_done;

	bsr_div #(
		.DW(PW),
		.VW(WW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_go_q),
		.dividend  (q_q),
		.divisor   (w_eff),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	// window geometry
	logic [HW-1:0] oy_q;
	logic [WW-1:0] ox_q;
	logic [SW-1:0] up_q;
	logic [SW-1:0] down_q;
	logic [SW-1:0] left_q;
	logic [SW-1:0] right_q;
	logic [SW-1:0] rows_q;
	logic [SW-1:0] cols_q;
	logic [CW-1:0] area_q;
	logic [SW+WW-1:0] upw_q;
	logic [AW-1:0] base1_q;

	logic [SW-1:0] up_d;
	logic [SW-1:0] down_d;
	logic [SW-1:0] left_d;
	logic [SW-1:0] right_d;
	logic [SW-1:0] rows_d;
	logic [SW-1:0] cols_d;
	logic [2*SW-1:0] area_d;
	logic [SW+WW-1:0] upw_d;
	logic [AW:0] b1_diff;
	logic [AW-1:0] base1_d;
	logic [AW:0] b2_diff;
	logic [AW-1:0] base_d;

	always_comb begin
		up_d = (int'(oy_q) < int'(lo)) ? SW'(oy_q) : lo;
		down_d = (int'(oy_q) + int'(hi) > int'(h_eff) - 1) ?
			SW'(int'(h_eff) - 1 - int'(oy_q)) : hi;
		left_d = (int'(ox_q) < int'(lo)) ? SW'(ox_q) : lo;
		right_d = (int'(ox_q) + int'(hi) > int'(w_eff) - 1) ?
			SW'(int'(w_eff) - 1 - int'(ox_q)) : hi;
		rows_d = SW'(int'(up_q) + int'(down_q) + 1);
		cols_d = SW'(int'(left_q) + int'(right_q) + 1);
		area_d = rows_d * cols_d;
		upw_d = up_q * w_eff;
		b1_diff = {1'b0, qmod_q} - (AW + 1)'(upw_q);
		base1_d = (qmod_q >= upw_q) ? AW'(b1_diff) : AW'(b1_diff + DEPTH_X);
		b2_diff = {1'b0, base1_q} - (AW + 1)'(left_q);
		base_d = (base1_q >= left_q) ? AW'(b2_diff) : AW'(b2_diff + DEPTH_X);
	end

	// window scan
	logic [AW-1:0] row_addr_q;
	logic [AW-1:0] scan_addr_q;
	logic [SW-1:0] r_q;
	logic [SW-1:0] c_q;
	logic [CW-1:0] count_q;
	logic pend_s1;
	logic [1:0] centre_q;
	logic [LW-1:0] lhs_q;
	logic [LW-1:0] rhs_q;

	logic row_end;
	logic scan_last;
	logic [AW-1:0] addr_inc;
	logic [AW:0] row_sum;
	logic [AW-1:0] row_next;
	logic [LW-1:0] lhs_d;
	logic [LW-1:0] rhs_d;
	logic [1:0] rd_data;

	assign row_end = c_q == (cols_q - SW'(1));
	assign scan_last = row_end && (r_q == (rows_q - SW'(1)));
	assign addr_inc = (scan_addr_q == AW'(DEPTH - 1)) ? '0 : scan_addr_q + AW'(1);
	assign row_sum = {1'b0, row_addr_q} + (AW + 1)'(w_eff);
	assign row_next = (row_sum >= DEPTH_X) ? AW'(row_sum - DEPTH_X) : AW'(row_sum);
	assign lhs_d = count_q * PERCENT;
	assign rhs_d = ratio_q * area_q;

	bsr_ram #(
		.WIDTH(2),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.decide && below_n && !op_q),
		.waddr (RAW'(pos_mod_q)),
		.wdata (code_of(pix_q)),
		.re    (cmd.ld_addr1 | cmd.scan_step),
		.raddr (cmd.ld_addr1 ? RAW'(qmod_q) : RAW'(scan_addr_q)),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= cmd.scan_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			op_q <= op;
			pix_q <= pixel_in;
		end
		if (cmd.ld_cfg) begin
			n_q <= PW'(hw_prod);
			d_q <= PW'(d_full);
			dmod_q <= AW'(d_full);
		end
		if (cmd.decide) begin
			q_q <= q_now;
			qmod_q <= qmod_next;
		end
		if (cmd.ld_oxy) begin
			oy_q <= HW'(div_quo);
			ox_q <= div_rem;
		end
		if (cmd.ld_bounds) begin
			up_q <= up_d;
			down_q <= down_d;
			left_q <= left_d;
			right_q <= right_d;
		end
		if (cmd.ld_base) begin
			rows_q <= rows_d;
			cols_q <= cols_d;
			area_q <= CW'(area_d);
			upw_q <= upw_d;
		end
		if (cmd.ld_addr1) begin
			base1_q <= base1_d;
		end
		if (cmd.ld_addr2) begin
			centre_q <= rd_data;
			row_addr_q <= base_d;
			scan_addr_q <= base_d;
			r_q <= '0;
			c_q <= '0;
			count_q <= '0;
		end else begin
			if (pend_s1 && rd_data == CODE_COPIED) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.scan_step) begin
				if (row_end) begin
					c_q <= '0;
					r_q <= r_q + SW'(1);
					row_addr_q <= row_next;
					scan_addr_q <= row_next;
				end else begin
					c_q <= c_q + SW'(1);
					scan_addr_q <= addr_inc;
				end
			end
		end
		if (cmd.ld_cmp) begin
			lhs_q <= lhs_d;
			rhs_q <= rhs_d;
		end
	end

	// result register
	logic out_valid_q;
	logic [PIX_BITS-1:0] pixel_out_q;
	logic frame_last_q;
	logic [PIX_BITS-1:0] res_d;

	always_comb begin
		priority if (lhs_q >= rhs_q) begin
			res_d = PIX_FULL;
		end else if (centre_q == CODE_COPIED) begin
			res_d = PIX_COPIED;
		end else if (centre_q == CODE_PARTIAL) begin
			res_d = PIX_PARTIAL;
		end else begin
			res_d = PIX_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_res) begin
			pixel_out_q <= res_d;
			frame_last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign frame_last = frame_last_q;

	always_comb begin
		sts.div_done = div_done;
		sts.early = (below_n && op_q) || below_d || past_n;
		sts.scan_last = scan_last;
		sts.out_free = !out_valid_q || !out_stall;
	end

endmodule

// ===== design/bsr_ctrl.sv =====
// controller state machine sequencing one beat through the datapath
module bsr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  bsr_pkg::sts_t sts,
	output logic          in_stall,
	output bsr_pkg::cmd_t cmd
);
	import bsr_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_SETUP  = 13'b0000000000010,
		ST_DECIDE = 13'b0000000000100,
		ST_QGO    = 13'b0000000001000,
		ST_QW     = 13'b0000000010000,
		ST_BOUNDS = 13'b0000000100000,
		ST_BASE   = 13'b0000001000000,
		ST_ADDR1  = 13'b0000010000000,
		ST_ADDR2  = 13'b0000100000000,
		ST_SCAN   = 13'b0001000000000,
		ST_TAIL   = 13'b0010000000000,
		ST_CMP    = 13'b0100000000000,
		ST_RES    = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.ld_cfg = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = sts.early ? ST_IDLE : ST_QGO;
			end
			ST_QGO: begin
				cmd.div_go_q = 1'b1;
				state_d = ST_QW;
			end
			ST_QW: begin
				if (sts.div_done) begin
					cmd.ld_oxy = 1'b1;
					state_d = ST_BOUNDS;
				end
			end
			ST_BOUNDS: begin
				cmd.ld_bounds = 1'b1;
				state_d = ST_BASE;
			end
			ST_BASE: begin
				cmd.ld_base = 1'b1;
				state_d = ST_ADDR1;
			end
			ST_ADDR1: begin
				cmd.ld_addr1 = 1'b1;
				state_d = ST_ADDR2;
			end
			ST_ADDR2: begin
				cmd.ld_addr2 = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.ld_cmp = 1'b1;
				state_d = ST_RES;
			end
			ST_RES: begin
				if (sts.out_free) begin
					cmd.ld_res = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/box_support_relabel.sv =====
// top level of the box support relabel block
// Relabels a raster-order label frame by the share of 255 pixels in a clipped square window
// around each pixel; results lag the input by dn*W + dn beats (dn = lower window reach) and
// the frame is drained by as many flush beats. One beat is handled at a time. A beat that
// gives a result runs the bit-serial divider for the row/column split and then reads the
// clipped window one label per cycle from the label store (one write and one read port)
// before the next beat can be taken, and it waits longer while out_stall still holds the
// result register. Beats that give no result skip the divider and the scan. The store
// address follows the frame position as a wrapping counter. The label store is not
// cleared after reset. A finished result waits in the output register while the next
// beat is taken.
module box_support_relabel #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SUPPORT = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bsr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [bsr_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic [bsr_pkg::PIX_BITS-1:0]      pixel_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bsr_pkg::PIX_BITS-1:0]      pixel_out,
	output logic                              frame_last
);
	import bsr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	bsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	bsr_dpath #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_SUPPORT (MAX_SUPPORT)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.pixel_in   (pixel_in),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.pixel_out  (pixel_out),
		.frame_last (frame_last)
	);

endmodule

// ===== design/bsr_checker.sv =====
// port-level checks for the box support relabel block, bound to the top level
module bsr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [bsr_pkg::PIX_BITS-1:0] pixel_out,
	input logic                         frame_last
);
	import bsr_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_last))
		else $error("stalled result beat changed");

	a_out_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_out == PIX_FULL || pixel_out == PIX_COPIED ||
			pixel_out == PIX_PARTIAL || pixel_out == PIX_NONE)
		else $error("result label out of set");

	// one beat at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while beat in flight");

endmodule

bind box_support_relabel bsr_checker u_bsr_checker (.*);

// ===== tb/sv/box_support_relabel_tb.sv =====
// self-checking testbench for the box support relabel block
module box_support_relabel_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsr_pkg::*;

	localparam int LABEL_DEPTH = 32 * 1024 + 32;
	localparam int SETTLE_CYCLES = 1500;
	localparam int HOLD_CYCLES = 2000;
	localparam int STALL_LIMIT = 40000;

	typedef struct {
		logic [PIX_BITS-1:0] pix;
		logic last;
	} relabel_t;

	class relabel_scoreboard;
		logic [1:0] labels[LABEL_DEPTH];
		int unsigned width_reg = 1024, height_reg = 1024, support_reg = 8, ratio_reg = 50;
		longint unsigned pos;
		relabel_t pending[$];
		int errors, results, beats;

		function void set_reg(cfg_idx_t idx, int unsigned val);
			case (idx)
				CFG_WIDTH: width_reg = val & 32'h7ff;
				CFG_HEIGHT: height_reg = val & 32'h1fffff;
				CFG_SUPPORT: support_reg = val & 32'h3f;
				CFG_RATIO: ratio_reg = val & 32'h7f;
			endcase
		endfunction

		function void note_input(logic is_flush, logic [PIX_BITS-1:0] pix);
			longint unsigned w, h, s, lo, hi, n, d, q, oy, ox, up, dn, lf, rt, r, c, cnt, area;
			logic [1:0] centre;
			relabel_t e;
			beats++;
			w = width_reg;
			h = height_reg;
			s = support_reg;
			if (w < 1) w = 1;
			if (w > 1024) w = 1024;
			if (h < 1) h = 1;
			if (s < 1) s = 1;
			if (s > 32) s = 32;
			lo = s / 2;
			hi = s - lo - 1;
			n = h * w;
			d = hi * w + hi;
			if (pos < n) begin
				if (is_flush)
					return;
				labels[pos % LABEL_DEPTH] = (pix == PIX_FULL) ? CODE_COPIED :
					(pix != 0) ? CODE_PARTIAL : CODE_NONE;
			end
			if (pos < d) begin
				pos++;
				return;
			end
			q = pos - d;
			if (q >= n) begin
				pos = 0;
				return;
			end
			oy = q / w;
			ox = q % w;
			up = (oy < lo) ? oy : lo;
			dn = (oy + hi > h - 1) ? (h - 1 - oy) : hi;
			lf = (ox < lo) ? ox : lo;
			rt = (ox + hi > w - 1) ? (w - 1 - ox) : hi;
			cnt = 0;
			for (r = oy - up; r <= oy + dn; r++)
				for (c = ox - lf; c <= ox + rt; c++)
					if (labels[(r * w + c) % LABEL_DEPTH] == CODE_COPIED)
						cnt++;
			area = (up + dn + 1) * (lf + rt + 1);
			centre = labels[q % LABEL_DEPTH];
			if ((cnt * PERCENT) / area >= ratio_reg)
				e.pix = PIX_FULL;
			else if (centre == CODE_COPIED)
				e.pix = PIX_COPIED;
			else if (centre == CODE_PARTIAL)
				e.pix = PIX_PARTIAL;
			else
				e.pix = PIX_NONE;
			e.last = (q == n - 1);
			pos = e.last ? 0 : pos + 1;
			pending.push_back(e);
		endfunction

		function void check(logic [PIX_BITS-1:0] pix, logic last);
			relabel_t e;
			results++;
			if (pending.size() == 0) begin
				$error("unexpected result beat pixel_out=%0d frame_last=%0d", pix, last);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (pix !== e.pix) begin
				$error("pixel_out expected %0d actual %0d", e.pix, pix);
				errors++;
			end
			if (last !== e.last) begin
				$error("frame_last expected %0d actual %0d", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid, in_stall, op;
	logic [PIX_BITS-1:0] pixel_in;
	logic out_valid, out_stall, frame_last;
	logic [PIX_BITS-1:0] pixel_out;
	logic [PIX_BITS-1:0] seed_row[6] = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd254, 8'd255};

	relabel_scoreboard sb = new();
	bit calm, hold_req;
	int frames, quiet_cycles;

	box_support_relabel dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check(pixel_out, frame_last);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end
			out_stall <= !calm && ($urandom_range(99) < 27);
		end
	end

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send(logic is_flush, logic [PIX_BITS-1:0] pix);
		if (!calm && $urandom_range(99) < 27) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		op <= is_flush;
		pixel_in <= pix;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(is_flush, pix);
	endtask

	task automatic settle();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [PIX_BITS-1:0] pick_label();
		int k;
		k = $urandom_range(99);
		if (k < 40) return PIX_FULL;
		if (k < 60) return PIX_NONE;
		return PIX_BITS'($urandom_range(255));
	endfunction

	// full frame: pixels with some ignored flushes, then the drain beats
	task automatic run_frame(int unsigned w, int unsigned h, int unsigned s, int unsigned r,
			bit noisy);
		int unsigned wc, hc, sc, hi, n, d;
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_SUPPORT, s);
		write_reg(CFG_RATIO, r);
		wc = (w == 0) ? 1 : (w > 1024) ? 1024 : w;
		hc = (h == 0) ? 1 : h;
		sc = (s == 0) ? 1 : (s > 32) ? 32 : s;
		hi = sc - sc / 2 - 1;
		n = wc * hc;
		d = hi * wc + hi;
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(99) < 5)
				send(1, PIX_BITS'($urandom_range(255)));
			send(0, pick_label());
		end
		for (int i = 0; i < d; i++)
			send(!(noisy && $urandom_range(99) < 8), PIX_BITS'($urandom_range(255)));
		frames++;
		settle();
	endtask

	initial begin
		cfg_valid = 0;
		cfg_index = CFG_WIDTH;
		cfg_data = 0;
		in_valid = 0;
		op = 0;
		pixel_in = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: border windows, flush during input, pixel during drain
		write_reg(CFG_WIDTH, 4);
		write_reg(CFG_HEIGHT, 3);
		write_reg(CFG_SUPPORT, 3);
		write_reg(CFG_RATIO, 50);
		foreach (seed_row[i])
			send(0, seed_row[i]);
		send(1, 8'd0);
		for (int i = 0; i < 6; i++)
			send(0, (i % 2) ? PIX_FULL : 8'd127);
		send(0, 8'd255);
		for (int i = 0; i < 4; i++)
			send(1, 8'd0);
		frames++;
		settle();

		// config change mid-frame: height shrinks below the counter
		write_reg(CFG_WIDTH, 4);
		write_reg(CFG_HEIGHT, 4);
		write_reg(CFG_SUPPORT, 1);
		write_reg(CFG_RATIO, 0);
		for (int i = 0; i < 6; i++)
			send(0, pick_label());
		settle();
		write_reg(CFG_HEIGHT, 1);
		send(0, 8'd255);
		settle();
		run_frame(4, 1, 1, 101, 0);

		// extreme register values
		write_reg(CFG_HEIGHT, 1048576);
		write_reg(CFG_HEIGHT, 2097151);
		run_frame(0, 3, 63, 127, 1);
		run_frame(2047, 0, 1, 0, 0);
		// long receiver hold-off while the sender keeps offering
		hold_req = 1;
		run_frame(3, 2, 32, 100, 1);
		run_frame(1, 1, 0, 1, 0);

		// random frames
		while (sb.beats < 1300) begin
			int unsigned s, r, k;
			calm = (frames % 10 >= 7);
			k = $urandom_range(9);
			s = (k == 0) ? 32 : (k == 1) ? 1 : (k < 5) ? $urandom_range(63) : $urandom_range(2, 6);
			k = $urandom_range(9);
			r = (k == 0) ? 0 : (k == 1) ? 100 : (k == 2) ? 101 : (k < 5) ? $urandom_range(127)
				: $urandom_range(20, 80);
			run_frame($urandom_range(1, 8), $urandom_range(1, 6), s, r, $urandom_range(3) == 0);
		end
		calm = 0;
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d input beats and %0d result beats over %0d frames",
			sb.beats, sb.results, frames);
		$display("incl. clipped borders, ratio 0/100/101+, clamped registers and a long hold-off");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== box_support_relabel.f =====
design/bsr_pkg.sv
design/bsr_ram.sv
design/bsr_div.sv
design/bsr_dpath.sv
design/bsr_ctrl.sv
design/box_support_relabel.sv
design/bsr_checker.sv
tb/sv/box_support_relabel_tb.sv
